/* rtl/gbm_pkg.sv */
// Shared constants, types and divisor tables for the GBM path engine.
// No dependencies; every other file in rtl imports this package.
`timescale 1ns / 1ps

package gbm_pkg;

    localparam int VALUE_BITS   = 32;
    localparam int COUNT_BITS   = 20;
    localparam int COEF_BITS    = 32;
    localparam int ZMAG_BITS    = 28;
    localparam int SUM_BITS     = VALUE_BITS + COUNT_BITS;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_START = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRIFT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NOISE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEPS = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PATHS = 3'd4;

    localparam logic [VALUE_BITS-1:0] RST_START = 32'd16777216;
    localparam logic [COEF_BITS-1:0]  RST_DRIFT = 32'd107374;
    localparam logic [COEF_BITS-1:0]  RST_NOISE = 32'd2147484;
    localparam logic [COUNT_BITS-1:0] RST_STEPS = 20'd10000;
    localparam logic [COUNT_BITS-1:0] RST_PATHS = 20'd1024;

    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] TWO_LN2_Q30 = 32'd1488522236;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

    typedef struct packed {
        logic                 neg;
        logic [ZMAG_BITS-1:0] mag;
    } t_sample;

    typedef struct packed {
        logic [VALUE_BITS-1:0]       start_value;
        logic signed [COEF_BITS-1:0] drift_step;
        logic signed [COEF_BITS-1:0] noise_scale;
        logic [COUNT_BITS-1:0]       steps_per_path;
        logic [COUNT_BITS-1:0]       path_count;
    } t_cfg;

    typedef struct packed {
        logic [5:0]  divisor;
        logic [31:0] recip;
    } t_div_const;

    // Divisors of the Taylor series in Horner order, with floor(2^32 / d).
    function automatic t_div_const div_const(input logic sin_sel, input logic [1:0] stage);
        t_div_const d;
        begin
            if (sin_sel) begin
                unique case (stage)
                    2'd0:    d = '{6'd42, 32'd102261126};
                    2'd1:    d = '{6'd20, 32'd214748364};
                    2'd2:    d = '{6'd6,  32'd715827882};
                    default: d = '{6'd2,  32'd2147483648};
                endcase
            end else begin
                unique case (stage)
                    2'd0:    d = '{6'd56, 32'd76695844};
                    2'd1:    d = '{6'd30, 32'd143165576};
                    2'd2:    d = '{6'd12, 32'd357913941};
                    default: d = '{6'd2,  32'd2147483648};
                endcase
            end
            return d;
        end
    endfunction

endpackage

/* rtl/gbm_front.sv */
// Front end: takes a pair of uniform words and turns it into a normal sample.
// Sequencer around one shared 32x32 multiplier; depends on gbm_pkg.
`timescale 1ns / 1ps

module gbm_front import gbm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_uniform_radius,
    input  logic [31:0] i_uniform_angle,
    output logic        o_push,
    output t_sample     o_sample,
    input  logic        i_full
);

    typedef enum logic [12:0] {
        F_IDLE   = 13'b0000000000001,
        F_NORM   = 13'b0000000000010,
        F_LOG    = 13'b0000000000100,
        F_LSCALE = 13'b0000000001000,
        F_SQRT   = 13'b0000000010000,
        F_XMUL   = 13'b0000000100000,
        F_X2     = 13'b0000001000000,
        F_VMUL   = 13'b0000010000000,
        F_RECIP  = 13'b0000100000000,
        F_CORR   = 13'b0001000000000,
        F_SINMUL = 13'b0010000000000,
        F_ZMUL   = 13'b0100000000000,
        F_PUSH   = 13'b1000000000000
    } t_fstate;

    t_fstate     r_state, n_state;
    logic [31:0] r_m, n_m;
    logic [4:0]  r_e, n_e;
    logic [23:0] r_frac, n_frac;
    logic [4:0]  r_cnt, n_cnt;
    logic [53:0] r_sq_n, n_sq_n;
    logic [55:0] r_sq_res, n_sq_res;
    logic [54:0] r_sq_bit, n_sq_bit;
    logic [29:0] r_p, n_p;
    logic        r_neg, n_neg;
    logic        r_sin, n_sin;
    logic [30:0] r_x, n_x;
    logic [30:0] r_x2, n_x2;
    logic [30:0] r_t, n_t;
    logic [30:0] r_v, n_v;
    logic [30:0] r_q0, n_q0;
    logic [30:0] r_c, n_c;
    logic [1:0]  r_stage, n_stage;
    t_sample     r_z, n_z;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] prod_r29, prod_r30;
    logic [29:0] nl2;
    logic [32:0] fp0, fp1, fp2, fp3;
    logic        f_neg, f_sin;
    logic [32:0] sq_t;
    logic [55:0] sq_rb;
    t_div_const  dc;
    logic [36:0] q0d;
    logic [36:0] rem;
    logic [30:0] q;

    assign nl2 = {(6'd32 - {1'b0, r_e}), 24'd0} - {6'd0, r_frac};
    assign dc  = div_const(r_sin, r_stage);

    always_comb begin
        unique case (r_state)
            F_LOG:    begin mul_a = r_m;                  mul_b = r_m;             end
            F_LSCALE: begin mul_a = {2'b0, nl2};          mul_b = TWO_LN2_Q30;     end
            F_XMUL:   begin mul_a = {2'b0, r_p};          mul_b = PI_Q30;          end
            F_X2:     begin mul_a = {1'b0, r_x};          mul_b = {1'b0, r_x};     end
            F_VMUL:   begin mul_a = {1'b0, r_x2};         mul_b = {1'b0, r_t};     end
            F_RECIP:  begin mul_a = {1'b0, r_v};          mul_b = dc.recip;        end
            F_SINMUL: begin mul_a = {1'b0, r_x};          mul_b = {1'b0, r_t};     end
            F_ZMUL:   begin mul_a = {4'b0, r_sq_res[27:0]}; mul_b = {1'b0, r_c};   end
            default:  begin mul_a = '0;                   mul_b = '0;              end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_r29 = prod + 64'h2000_0000;
    assign prod_r30 = prod + 64'h4000_0000;

    // Fold the angle into the first eighth of a turn.
    always_comb begin
        fp0   = {1'b0, i_uniform_angle};
        fp1   = (fp0 > 33'h0_8000_0000) ? (33'h1_0000_0000 - fp0) : fp0;
        f_neg = fp1 > 33'h0_4000_0000;
        fp2   = f_neg ? (33'h0_8000_0000 - fp1) : fp1;
        f_sin = fp2 > 33'h0_2000_0000;
        fp3   = f_sin ? (33'h0_4000_0000 - fp2) : fp2;
    end

    assign sq_t  = prod[63:31];
    assign sq_rb = r_sq_res + {1'b0, r_sq_bit};
    assign q0d   = {6'd0, r_q0} * {31'd0, dc.divisor};
    assign rem   = {6'd0, r_v} - q0d;
    assign q     = r_q0 + {30'd0, (rem >= {31'd0, dc.divisor})};

    always_comb begin
        n_state  = r_state;
        n_m      = r_m;
        n_e      = r_e;
        n_frac   = r_frac;
        n_cnt    = r_cnt;
        n_sq_n   = r_sq_n;
        n_sq_res = r_sq_res;
        n_sq_bit = r_sq_bit;
        n_p      = r_p;
        n_neg    = r_neg;
        n_sin    = r_sin;
        n_x      = r_x;
        n_x2     = r_x2;
        n_t      = r_t;
        n_v      = r_v;
        n_q0     = r_q0;
        n_c      = r_c;
        n_stage  = r_stage;
        n_z      = r_z;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_m     = (i_uniform_radius == 32'd0) ? 32'd1 : i_uniform_radius;
                    n_e     = 5'd31;
                    n_p     = fp3[29:0];
                    n_neg   = f_neg;
                    n_sin   = f_sin;
                    n_state = F_NORM;
                end
            end
            F_NORM: begin
                priority if (r_m[31]) begin
                    n_cnt   = '0;
                    n_frac  = '0;
                    n_state = F_LOG;
                end else if (r_m[31:16] == 16'd0) begin
                    n_m = {r_m[15:0], 16'd0};
                    n_e = r_e - 5'd16;
                end else if (r_m[31:24] == 8'd0) begin
                    n_m = {r_m[23:0], 8'd0};
                    n_e = r_e - 5'd8;
                end else if (r_m[31:28] == 4'd0) begin
                    n_m = {r_m[27:0], 4'd0};
                    n_e = r_e - 5'd4;
                end else if (r_m[31:30] == 2'd0) begin
                    n_m = {r_m[29:0], 2'd0};
                    n_e = r_e - 5'd2;
                end else begin
                    n_m = {r_m[30:0], 1'b0};
                    n_e = r_e - 5'd1;
                end
            end
            F_LOG: begin
                // Squaring the mantissa doubles the log; an overflow past two
                // yields the next fraction bit of the base-two logarithm.
                if (sq_t[32]) begin
                    n_m    = sq_t[32:1];
                    n_frac = {r_frac[22:0], 1'b1};
                end else begin
                    n_m    = sq_t[31:0];
                    n_frac = {r_frac[22:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd23) begin
                    n_state = F_LSCALE;
                end
            end
            F_LSCALE: begin
                n_sq_n   = {prod_r29[59:30], 24'd0};
                n_sq_res = '0;
                n_sq_bit = {1'b1, 54'd0};
                n_state  = F_SQRT;
            end
            F_SQRT: begin
                if ({2'b0, r_sq_n} >= sq_rb) begin
                    n_sq_n   = r_sq_n - sq_rb[53:0];
                    n_sq_res = (r_sq_res >> 1) + {1'b0, r_sq_bit};
                end else begin
                    n_sq_res = r_sq_res >> 1;
                end
                n_sq_bit = r_sq_bit >> 2;
                if (r_sq_bit[0]) begin
                    n_state = F_XMUL;
                end
            end
            F_XMUL: begin
                n_x     = prod_r30[61:31];
                n_state = F_X2;
            end
            F_X2: begin
                n_x2    = prod_r29[60:30];
                n_v     = prod_r29[60:30];
                n_stage = '0;
                n_state = F_RECIP;
            end
            F_VMUL: begin
                n_v     = prod_r29[60:30];
                n_state = F_RECIP;
            end
            F_RECIP: begin
                n_q0    = prod[62:32];
                n_state = F_CORR;
            end
            F_CORR: begin
                n_t     = Q30_ONE - q;
                n_stage = r_stage + 2'd1;
                priority if (!r_sin && r_stage == 2'd3) begin
                    n_c     = Q30_ONE - q;
                    n_state = F_ZMUL;
                end else if (r_sin && r_stage == 2'd2) begin
                    n_state = F_SINMUL;
                end else begin
                    n_state = F_VMUL;
                end
            end
            F_SINMUL: begin
                n_c     = prod_r29[60:30];
                n_state = F_ZMUL;
            end
            F_ZMUL: begin
                n_z.neg = r_neg;
                n_z.mag = prod_r29[57:30];
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m      <= n_m;
        r_e      <= n_e;
        r_frac   <= n_frac;
        r_cnt    <= n_cnt;
        r_sq_n   <= n_sq_n;
        r_sq_res <= n_sq_res;
        r_sq_bit <= n_sq_bit;
        r_p      <= n_p;
        r_neg    <= n_neg;
        r_sin    <= n_sin;
        r_x      <= n_x;
        r_x2     <= n_x2;
        r_t      <= n_t;
        r_v      <= n_v;
        r_q0     <= n_q0;
        r_c      <= n_c;
        r_stage  <= n_stage;
        r_z      <= n_z;
    end

    assign o_stall  = (r_state != F_IDLE);
    assign o_push   = (r_state == F_PUSH) && !i_full;
    assign o_sample = r_z;

endmodule

/* rtl/gbm_queue.sv */
// Four-entry sample queue between the normal generator and the path update.
// Depends on gbm_pkg for the sample type.
`timescale 1ns / 1ps

module gbm_queue import gbm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_sample i_data,
    output logic    o_full,
    input  logic    i_pop,
    output t_sample o_data,
    output logic    o_empty
);

    localparam int DEPTH = 4;

    t_sample    r_mem [DEPTH];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_count, n_count;

    always_comb begin
        n_wr    = i_push ? r_wr + 2'd1 : r_wr;
        n_rd    = i_pop ? r_rd + 2'd1 : r_rd;
        n_count = r_count + {2'd0, i_push} - {2'd0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_count == 3'(DEPTH));
    assign o_empty = (r_count == 3'd0);
    assign o_data  = r_mem[r_rd];

endmodule

/* rtl/gbm_back.sv */
// Back end: Euler-Maruyama update of the path value, step and path counting,
// mean over the run and the result register. Depends on gbm_pkg.
`timescale 1ns / 1ps

module gbm_back import gbm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_empty,
    input  t_sample               i_sample,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [VALUE_BITS-1:0] o_path_value,
    output logic [COUNT_BITS-1:0] o_path_number,
    output logic [VALUE_BITS-1:0] o_mean_value,
    output logic                  o_last_path
);

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_TERM  = 6'b000010,
        B_SCALE = 6'b000100,
        B_UPD   = 6'b001000,
        B_DIV   = 6'b010000,
        B_OUT   = 6'b100000
    } t_bstate;

    t_bstate               r_state, n_state;
    t_sample               r_z, n_z;
    logic signed [37:0]    r_g, n_g;
    logic                  r_gpos, n_gpos;
    logic [43:0]           r_a, n_a;
    logic [59:0]           r_b, n_b;
    logic [VALUE_BITS-1:0] r_x, n_x;
    logic [COUNT_BITS-1:0] r_step, n_step;
    logic [COUNT_BITS-1:0] r_path, n_path;
    logic [SUM_BITS-1:0]   r_sum, n_sum;
    logic [SUM_BITS-1:0]   r_dvd, n_dvd;
    logic [COUNT_BITS:0]   r_rem, n_rem;
    logic [5:0]            r_dcnt, n_dcnt;
    logic [VALUE_BITS-1:0] r_res_value, n_res_value;
    logic [COUNT_BITS-1:0] r_res_number, n_res_number;
    logic                  r_res_last, n_res_last;
    logic                  r_ovalid, n_ovalid;
    logic [VALUE_BITS-1:0] r_opath, n_opath;
    logic [COUNT_BITS-1:0] r_onum, n_onum;
    logic [VALUE_BITS-1:0] r_omean, n_omean;
    logic                  r_olast, n_olast;

    logic [31:0]           nmag;
    logic [59:0]           tprod;
    logic [37:0]           term;
    logic signed [37:0]    f;
    logic [60:0]           low_sum;
    logic [39:0]           scaled;
    logic [VALUE_BITS-1:0] x_new;
    logic [COUNT_BITS-1:0] steps_eff, paths_eff, step_next;
    logic                  close, last;
    logic [SUM_BITS-1:0]   sum_new;
    logic [COUNT_BITS+1:0] trial;
    logic                  qbit;
    logic [VALUE_BITS-1:0] mean_sat;
    logic                  out_free;

    assign nmag  = i_cfg.noise_scale[COEF_BITS-1] ? (32'd0 - i_cfg.noise_scale)
                                                  : i_cfg.noise_scale;
    assign tprod = {28'd0, nmag} * {32'd0, r_z.mag};
    assign term  = 38'((tprod + 60'h80_0000) >> 24);
    assign f     = (i_cfg.noise_scale[COEF_BITS-1] != r_z.neg)
                 ? (38'(i_cfg.drift_step) - $signed(term))
                 : (38'(i_cfg.drift_step) + $signed(term));

    // x * g / 2^30 in two partial products: integer byte and fraction bits.
    assign low_sum = {31'd0, r_a[5:0], 24'd0} + {1'b0, r_b} + 61'h2000_0000;
    assign scaled  = {2'b0, r_a[43:6]} + {9'd0, low_sum[60:30]};
    assign x_new   = !r_gpos ? '0 : ((|scaled[39:32]) ? '1 : scaled[31:0]);

    assign steps_eff = (i_cfg.steps_per_path == '0) ? 20'd1 : i_cfg.steps_per_path;
    assign paths_eff = (i_cfg.path_count == '0) ? 20'd1 : i_cfg.path_count;
    assign step_next = r_step + 20'd1;
    assign close     = (step_next == '0) || (step_next >= steps_eff);
    assign last      = ({1'b0, r_path} + 21'd1) >= {1'b0, paths_eff};
    assign sum_new   = r_sum + {20'd0, x_new};

    assign trial    = {1'b0, r_rem[COUNT_BITS-1:0], r_dvd[SUM_BITS-1]};
    assign qbit     = trial >= {2'b0, paths_eff};
    assign mean_sat = (|r_dvd[SUM_BITS-1:VALUE_BITS]) ? '1 : r_dvd[VALUE_BITS-1:0];
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        n_state      = r_state;
        n_z          = r_z;
        n_g          = r_g;
        n_gpos       = r_gpos;
        n_a          = r_a;
        n_b          = r_b;
        n_x          = r_x;
        n_step       = r_step;
        n_path       = r_path;
        n_sum        = r_sum;
        n_dvd        = r_dvd;
        n_rem        = r_rem;
        n_dcnt       = r_dcnt;
        n_res_value  = r_res_value;
        n_res_number = r_res_number;
        n_res_last   = r_res_last;
        n_ovalid     = r_ovalid && i_stall;
        n_opath      = r_opath;
        n_onum       = r_onum;
        n_omean      = r_omean;
        n_olast      = r_olast;
        o_pop        = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_z     = i_sample;
                    n_state = B_TERM;
                end
            end
            B_TERM: begin
                n_g     = f + 38'sh0_4000_0000;
                n_state = B_SCALE;
            end
            B_SCALE: begin
                n_gpos  = (r_g > 38'sd0);
                n_a     = {36'd0, r_x[31:24]} * {8'd0, r_g[35:0]};
                n_b     = {36'd0, r_x[23:0]} * {24'd0, r_g[35:0]};
                n_state = B_UPD;
            end
            B_UPD: begin
                if (!close) begin
                    n_x     = x_new;
                    n_step  = step_next;
                    n_state = B_IDLE;
                end else begin
                    n_res_value  = x_new;
                    n_res_number = r_path;
                    n_res_last   = last;
                    n_x          = i_cfg.start_value;
                    n_step       = '0;
                    if (last) begin
                        n_path  = '0;
                        n_sum   = '0;
                        n_dvd   = sum_new;
                        n_rem   = '0;
                        n_dcnt  = '0;
                        n_state = B_DIV;
                    end else begin
                        n_path  = r_path + 20'd1;
                        n_sum   = sum_new;
                        n_state = B_OUT;
                    end
                end
            end
            B_DIV: begin
                // Restoring division, one quotient bit per cycle.
                n_rem  = qbit ? (trial[COUNT_BITS:0] - {1'b0, paths_eff})
                              : trial[COUNT_BITS:0];
                n_dvd  = {r_dvd[SUM_BITS-2:0], qbit};
                n_dcnt = r_dcnt + 6'd1;
                if (r_dcnt == 6'(SUM_BITS - 1)) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_opath  = r_res_value;
                    n_onum   = r_res_number;
                    n_olast  = r_res_last;
                    n_omean  = r_res_last ? mean_sat : '0;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_x      <= RST_START;
            r_step   <= '0;
            r_path   <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_x      <= n_x;
            r_step   <= n_step;
            r_path   <= n_path;
            r_sum    <= n_sum;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z          <= n_z;
        r_g          <= n_g;
        r_gpos       <= n_gpos;
        r_a          <= n_a;
        r_b          <= n_b;
        r_dvd        <= n_dvd;
        r_rem        <= n_rem;
        r_dcnt       <= n_dcnt;
        r_res_value  <= n_res_value;
        r_res_number <= n_res_number;
        r_res_last   <= n_res_last;
        r_opath      <= n_opath;
        r_onum       <= n_onum;
        r_omean      <= n_omean;
        r_olast      <= n_olast;
    end

    assign o_valid       = r_ovalid;
    assign o_path_value  = r_opath;
    assign o_path_number = r_onum;
    assign o_mean_value  = r_omean;
    assign o_last_path   = r_olast;

endmodule

/* rtl/gbm_euler_maruyama_path_engine.sv */
// Top level of the GBM path engine: configuration registers and the
// front end, sample queue and back end. Depends on gbm_pkg.
`timescale 1ns / 1ps

// Each input transfer carries two uniform words and advances the simulated
// path by one Euler-Maruyama step; a result appears once per finished path,
// and the result closing the last path also carries the run mean. The front
// end takes no new input until the current one is through its sequencer
// around a single shared multiplier (24 logarithm squarings and a 28-step
// square root dominate). The back end passes through its term, scale and
// update states for each step and divides the run sum at the end of a
// run; a four-entry sample queue and a result register let both sides stall
// independently. Configuration writes are always ready and must only be
// made while the engine is idle.

module gbm_euler_maruyama_path_engine import gbm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [31:0]             i_uniform_radius,
    input  logic [31:0]             i_uniform_angle,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [VALUE_BITS-1:0]   o_path_value,
    output logic [COUNT_BITS-1:0]   o_path_number,
    output logic [VALUE_BITS-1:0]   o_mean_value,
    output logic                    o_last_path,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [31:0]             i_cfg_data
);

    t_cfg    r_cfg, n_cfg;
    logic    push, full, pop, empty;
    t_sample push_data, pop_data;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START: n_cfg.start_value    = i_cfg_data;
                CFG_DRIFT: n_cfg.drift_step     = i_cfg_data;
                CFG_NOISE: n_cfg.noise_scale    = i_cfg_data;
                CFG_STEPS: n_cfg.steps_per_path = i_cfg_data[COUNT_BITS-1:0];
                CFG_PATHS: n_cfg.path_count     = i_cfg_data[COUNT_BITS-1:0];
                default:   n_cfg                = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{RST_START, RST_DRIFT, RST_NOISE, RST_STEPS, RST_PATHS};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    gbm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_uniform_radius (i_uniform_radius),
        .i_uniform_angle  (i_uniform_angle),
        .o_push           (push),
        .o_sample         (push_data),
        .i_full           (full)
    );

    gbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_empty (empty)
    );

    gbm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_empty       (empty),
        .i_sample      (pop_data),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_path_value  (o_path_value),
        .o_path_number (o_path_number),
        .o_mean_value  (o_mean_value),
        .o_last_path   (o_last_path)
    );

endmodule

/* rtl/gbm_checker.sv */
// Port-level checks for the GBM path engine, bound to the top level.
// Depends on gbm_pkg for widths.
`timescale 1ns / 1ps

module gbm_checker import gbm_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic [VALUE_BITS-1:0]   o_path_value,
    input logic [COUNT_BITS-1:0]   o_path_number,
    input logic [VALUE_BITS-1:0]   o_mean_value,
    input logic                    o_last_path
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_path_value) && $stable(o_path_number)
            && $stable(o_last_path))
        else $error("result changed while stalled");

    a_mean_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_path |-> o_mean_value == '0)
        else $error("mean shown on a result that does not close the run");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("front end did not go busy after a transfer");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind gbm_euler_maruyama_path_engine gbm_checker u_checker (.*);

/* bench/testbench.sv */
// Self-checking bench for the GBM Euler-Maruyama path engine: a bit-exact
// path predictor, directed and random stimulus with random idling on both sides.
// Depends on gbm_pkg and the gbm_euler_maruyama_path_engine RTL.
`timescale 1ns / 1ps

module testbench;
    import gbm_pkg::*;

    typedef struct {
        logic [VALUE_BITS-1:0] path_value;
        logic [COUNT_BITS-1:0] path_number;
        logic [VALUE_BITS-1:0] mean_value;
        logic                  last_path;
    } t_path_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [31:0]             i_uniform_radius = '0;
    logic [31:0]             i_uniform_angle = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [VALUE_BITS-1:0]   o_path_value;
    logic [COUNT_BITS-1:0]   o_path_number;
    logic [VALUE_BITS-1:0]   o_mean_value;
    logic                    o_last_path;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [31:0]             i_cfg_data = '0;

    // Predictor state and its copy of the registers.
    t_cfg         model_cfg;
    bit [63:0]    walk_value, walk_step, walk_path, walk_sum;
    t_path_result pending_paths[$];

    int errors = 0;
    int items_sent = 0;
    int paths_seen = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit rx_hold = 1'b0;

    gbm_euler_maruyama_path_engine uut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= rx_hold || ($urandom_range(99) < rx_stall_pct);
    end

    initial begin
        #4ms;
        $display("testbench failed");
        $finish;
    end

    // -2 ln(u / 2^32) in Q.24 by repeated squaring of the mantissa.
    function automatic bit [63:0] neg_two_log(input bit [63:0] u);
        int        e = 31;
        bit [63:0] m = u;
        bit [63:0] frac = 0;
        bit [63:0] nl2;
        while (m[31] == 1'b0) begin
            m = m << 1;
            e--;
        end
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        nl2 = (64'(32 - e) << 24) - frac;
        return (nl2 * 64'(TWO_LN2_Q30) + 64'd536870912) >> 30;
    endfunction

    function automatic bit [63:0] int_sqrt(input bit [63:0] n);
        bit [63:0] res = 0;
        bit [63:0] b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit [63:0] q30_mul(input bit [63:0] a, input bit [63:0] b);
        return (a * b + 64'd536870912) >> 30;
    endfunction

    // |cos| of a fraction of a turn in Q2.30, folded into one eighth.
    function automatic bit [63:0] turn_cosine(input bit [63:0] p, output bit neg);
        bit [63:0] one = 64'd1 << 30;
        bit [63:0] x, x2, t;
        bit        sin_fold = 1'b0;
        neg = 1'b0;
        if (p > (64'd1 << 31)) p = 64'h1_0000_0000 - p;
        if (p > one) begin
            p = (64'd1 << 31) - p;
            neg = 1'b1;
        end
        if (p > (one >> 1)) begin
            p = one - p;
            sin_fold = 1'b1;
        end
        x = (p * 64'(PI_Q30) + one) >> 31;
        x2 = q30_mul(x, x);
        if (sin_fold) begin
            t = one - x2 / 42;
            t = one - q30_mul(x2, t) / 20;
            t = one - q30_mul(x2, t) / 6;
            return q30_mul(x, t);
        end
        t = one - x2 / 56;
        t = one - q30_mul(x2, t) / 30;
        t = one - q30_mul(x2, t) / 12;
        return one - q30_mul(x2, t) / 2;
    endfunction

    function automatic bit [63:0] scaled_value(input bit [63:0] x, input bit [63:0] g);
        bit [63:0] a = (x >> 24) * g;
        bit [63:0] b = (x & 64'hFF_FFFF) * g;
        bit [63:0] r = (a >> 6) + ((((a & 64'd63) << 24) + b + 64'd536870912) >> 30);
        return (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
    endfunction

    // Advances the predicted path by one step; returns 1 when a path closes.
    function automatic bit path_step(input bit [31:0] u1_word, input bit [31:0] u2_word,
                                     output t_path_result res);
        bit [63:0] steps = (model_cfg.steps_per_path == 0) ? 1 : 64'(model_cfg.steps_per_path);
        bit [63:0] paths = (model_cfg.path_count == 0) ? 1 : 64'(model_cfg.path_count);
        bit [63:0] u1 = (u1_word == 0) ? 64'd1 : 64'(u1_word);
        bit [63:0] r, c, zmag, nmag, term, mean;
        bit        cneg, nneg, last;
        longint    f, g;
        r = int_sqrt(neg_two_log(u1) << 24);
        c = turn_cosine(64'(u2_word), cneg);
        zmag = (r * c + 64'd536870912) >> 30;
        nneg = model_cfg.noise_scale < 0;
        nmag = nneg ? 64'(-longint'(model_cfg.noise_scale)) : 64'(model_cfg.noise_scale);
        term = (nmag * zmag + (64'd1 << 23)) >> 24;
        f = (nneg != cneg) ? longint'(model_cfg.drift_step) - longint'(term)
                           : longint'(model_cfg.drift_step) + longint'(term);
        g = (longint'(1) << 30) + f;
        walk_value = (g <= 0) ? 64'd0 : scaled_value(walk_value, 64'(g));
        walk_step = (walk_step + 1) & 64'hF_FFFF;
        if (walk_step != 0 && walk_step < steps) return 1'b0;
        last = walk_path + 1 >= paths;
        res.path_value = walk_value[31:0];
        res.path_number = walk_path[19:0];
        res.mean_value = '0;
        res.last_path = last;
        walk_sum = (walk_sum > ~walk_value) ? '1 : walk_sum + walk_value;
        if (last) begin
            mean = walk_sum / paths;
            res.mean_value = (mean > 64'hFFFF_FFFF) ? '1 : mean[31:0];
            walk_sum = 0;
            walk_path = 0;
        end else begin
            walk_path = (walk_path + 1) & 64'hF_FFFF;
        end
        walk_value = 64'(model_cfg.start_value);
        walk_step = 0;
        return 1'b1;
    endfunction

    always @(negedge i_clk) begin
        t_path_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            paths_seen++;
            if (pending_paths.size() == 0) begin
                $error("unexpected result: path_value %h path_number %0d",
                       o_path_value, o_path_number);
                errors++;
            end else begin
                want = pending_paths.pop_front();
                if (o_path_value !== want.path_value) begin
                    $error("path_value: expected %h, got %h", want.path_value, o_path_value);
                    errors++;
                end
                if (o_path_number !== want.path_number) begin
                    $error("path_number: expected %0d, got %0d",
                           want.path_number, o_path_number);
                    errors++;
                end
                if (o_mean_value !== want.mean_value) begin
                    $error("mean_value: expected %h, got %h", want.mean_value, o_mean_value);
                    errors++;
                end
                if (o_last_path !== want.last_path) begin
                    $error("last_path: expected %b, got %b", want.last_path, o_last_path);
                    errors++;
                end
            end
        end
    end

    // Offers one pair of uniform words and returns after its transfer.
    // Valid stays high afterwards; release_input lowers it.
    task automatic send_uniforms(input bit [31:0] radius, input bit [31:0] angle);
        bit           taken;
        t_path_result res;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_uniform_radius <= radius;
        i_uniform_angle <= angle;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        items_sent++;
        if (path_step(radius, angle, res)) pending_paths.push_back(res);
    endtask

    task automatic release_input();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits for every predicted path, then lets the front end settle.
    task automatic drain_paths();
        release_input();
        while (pending_paths.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input bit [31:0] data);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        case (idx)
            CFG_START: model_cfg.start_value = data;
            CFG_DRIFT: model_cfg.drift_step = data;
            CFG_NOISE: model_cfg.noise_scale = data;
            CFG_STEPS: model_cfg.steps_per_path = data[19:0];
            CFG_PATHS: model_cfg.path_count = data[19:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_engine(input bit [31:0] start, input bit [31:0] drift,
                              input bit [31:0] noise, input bit [19:0] steps,
                              input bit [19:0] paths);
        write_register(CFG_START, start);
        write_register(CFG_DRIFT, drift);
        write_register(CFG_NOISE, noise);
        write_register(CFG_STEPS, steps);
        write_register(CFG_PATHS, paths);
    endtask

    task automatic test_directed_samples();
        bit [31:0] radii[8] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000,
                                32'h0000_FFFF, 32'h4000_0000, 32'h7FFF_FFFF, 32'hC000_0001};
        bit [31:0] angles[10] = '{32'd0, 32'h2000_0000, 32'h2000_0001, 32'h4000_0000,
                                  32'h4000_0001, 32'h6000_0000, 32'h8000_0000,
                                  32'h8000_0001, 32'hC000_0000, 32'hFFFF_FFFF};
        set_engine(32'h0100_0000, 32'd107374, 32'h2000_0000, 20'd1, 20'd4);
        for (int i = 0; i < 10; i++) send_uniforms(radii[i % 8], angles[i]);
        for (int i = 0; i < 6; i++) send_uniforms(radii[(i + 3) % 8], angles[9 - i]);
        drain_paths();
    endtask

    task automatic test_coefficient_extremes();
        // A factor at or below zero collapses the path to zero.
        set_engine(32'h0100_0000, 32'h8000_0000, 32'd0, 20'd1, 20'd3);
        repeat (3) send_uniforms($urandom, $urandom);
        drain_paths();
        // Largest drift and noise from the largest start: saturation or zero.
        set_engine(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'd1, 20'd3);
        send_uniforms(32'd0, 32'd0);
        send_uniforms(32'd0, 32'h8000_0000);
        send_uniforms(32'h1234_5678, 32'h4000_0000);
        drain_paths();
        set_engine(32'd0, 32'd0, 32'h8000_0000, 20'd2, 20'd2);
        repeat (4) send_uniforms($urandom, $urandom);
        drain_paths();
        set_engine(32'h0300_0000, 32'd0, 32'h8000_0000, 20'd1, 20'd3);
        repeat (3) send_uniforms($urandom, $urandom);
        drain_paths();
    endtask

    task automatic test_count_limits();
        // Zero counts behave as one.
        set_engine(32'h0100_0000, 32'd107374, 32'd2147484, 20'd0, 20'd0);
        repeat (3) send_uniforms($urandom, $urandom);
        drain_paths();
        // Largest counts, then lowered part way through a path and a run.
        write_register(CFG_STEPS, 20'hF_FFFF);
        write_register(CFG_PATHS, 20'hF_FFFF);
        repeat (3) send_uniforms($urandom, $urandom);
        drain_paths();
        write_register(CFG_STEPS, 20'd2);
        send_uniforms($urandom, $urandom);
        repeat (2) send_uniforms($urandom, $urandom);
        drain_paths();
        write_register(CFG_PATHS, 20'd1);
        repeat (2) send_uniforms($urandom, $urandom);
        drain_paths();
        // A new start value applies from the next path only.
        write_register(CFG_STEPS, 20'd3);
        write_register(CFG_PATHS, 20'd2);
        send_uniforms($urandom, $urandom);
        drain_paths();
        write_register(CFG_START, 32'h0280_0000);
        repeat (5) send_uniforms($urandom, $urandom);
        drain_paths();
    endtask

    task automatic test_output_backpressure();
        set_engine(32'h0100_0000, 32'd107374, 32'h0100_0000, 20'd1, 20'd5);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        fork
            begin
                rx_hold = 1'b1;
                repeat (3000) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            repeat (20) send_uniforms($urandom, $urandom);
        join
        drain_paths();
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct, input int item_target);
        int        start_count = items_sent;
        int        burst;
        bit [31:0] drift, noise;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        while (items_sent - start_count < item_target) begin
            drift = ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(400000)) - 200000);
            noise = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(40000000));
            set_engine(($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1 << 26)),
                       drift, noise, 20'($urandom_range(1, 4)), 20'($urandom_range(1, 6)));
            burst = int'(model_cfg.steps_per_path) * int'(model_cfg.path_count)
                    * $urandom_range(1, 3);
            repeat (burst)
                send_uniforms(($urandom_range(15) == 0) ? 32'd0 : $urandom, $urandom);
            drain_paths();
        end
    endtask

    initial begin
        model_cfg = '{RST_START, RST_DRIFT, RST_NOISE, RST_STEPS, RST_PATHS};
        walk_value = 64'(RST_START);
        walk_step = 0;
        walk_path = 0;
        walk_sum = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 15;
        rx_stall_pct = 68;
        test_directed_samples();
        test_coefficient_extremes();
        test_count_limits();
        test_output_backpressure();
        random_phase(15, 68, 280);
        random_phase(68, 15, 280);
        random_phase(0, 0, 280);

        $display("Sent %0d uniform pairs and checked %0d finished paths across", items_sent,
                 paths_seen);
        $display("directed, coefficient, count-limit, backpressure and random phases.");
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
